### sv/sc1_pkg.sv
// ----------------------------------------------------------------------------
// sc1_pkg: shared types and constants for the scan code set 1 decoder
// Keymap columns, scan code values, action codes and the request format that
// runs from the classifier to the lookup stage.
// ----------------------------------------------------------------------------
package sc1_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned KeyW     = 6;
  localparam int unsigned KeymapN  = 64;

  localparam logic [ByteW-1:0] PREFIX_BYTE = 8'hE0;
  localparam logic [ByteW-1:0] MAX_CODE    = 8'd58;

  localparam logic [CharW-1:0] MK_LSHIFT = 7'h2A;
  localparam logic [CharW-1:0] MK_RSHIFT = 7'h36;
  localparam logic [CharW-1:0] MK_ALT    = 7'h38;
  localparam logic [CharW-1:0] MK_CTRL   = 7'h1D;
  localparam logic [CharW-1:0] MK_CAPS   = 7'h3A;

  localparam logic [CharW-1:0] KEY_ESC   = 7'h1B;
  localparam logic [CharW-1:0] KEY_BS    = 7'h08;
  localparam logic [CharW-1:0] KEY_TAB   = 7'h09;
  localparam logic [CharW-1:0] KEY_ENT   = 7'h0D;
  localparam logic [CharW-1:0] CHAR_NUL  = 7'h00;
  localparam logic [CharW-1:0] CHAR_SPC  = 7'h20;

  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_PRINT        = 3'd1,
    ACT_BACKSPACE    = 3'd2,
    ACT_UNKNOWN_KEY  = 3'd3,
    ACT_UNKNOWN_CHAR = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_SILENT = 2'd0,
    KIND_RANGE  = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } mods_t;

  typedef struct packed {
    kind_e           kind;
    logic [KeyW-1:0] key;
    logic            upper;
    mods_t           mods;
  } req_t;

  localparam logic [CharW-1:0] PLAIN_COL [KeymapN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CharW-1:0] SHIFT_COL [KeymapN] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

endpackage

### sv/sc1_if.sv
// ----------------------------------------------------------------------------
// sc1_if: valid/ready channels of the scan code set 1 decoder
// Input channel carries raw scan bytes, output channel carries decoded results.
// ----------------------------------------------------------------------------
interface sc1_in_if;
  import sc1_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface sc1_out_if;
  import sc1_pkg::*;

  logic             valid;
  logic             ready;
  logic [2:0]       action;
  logic [CharW-1:0] char_code;
  logic             shift_held;
  logic             ctrl_held;
  logic             alt_held;
  logic             caps_on;

  modport source (output valid, output action, output char_code, output shift_held,
                  output ctrl_held, output alt_held, output caps_on, input ready);
  modport sink   (input valid, input action, input char_code, input shift_held,
                  input ctrl_held, input alt_held, input caps_on, output ready);
endinterface

### sv/scan_code_set1_to_ascii.sv
// ----------------------------------------------------------------------------
// scan_code_set1_to_ascii: keyboard scan code set 1 to ASCII decoder
// Classifier, request queue and keymap lookup stage with a result register.
// ----------------------------------------------------------------------------
// Every accepted scan byte yields exactly one result: an action code, the
// ASCII character for print actions (tab prints a space) and the modifier
// flags as they stand after that byte. A byte 0xE0 arms the extended prefix
// for the next byte. A new byte is taken every clock cycle while the queue
// has room. The request is written into the queue when its byte is accepted
// and moves through the keymap lookup into the result register once it is at
// the head of the queue and the result register is free or being taken.
// The modifier and prefix flags update in the classifier in the cycle of
// acceptance, so back-to-back bytes see each other's effect. The queue holds
// QueueDepth requests, so up to QueueDepth + 1 results can be pending while
// the output side stalls.
// ----------------------------------------------------------------------------
module scan_code_set1_to_ascii #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sc1_in_if.sink    req_i,
  sc1_out_if.source rsp_o
);
  import sc1_pkg::*;

  logic push, push_ready, pop, head_valid;
  req_t push_data, head;

  sc1_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_ready_i (push_ready),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  sc1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  sc1_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

endmodule

### sv/sc1_front.sv
// ----------------------------------------------------------------------------
// sc1_front: scan byte classifier
// Tracks the extended prefix and the modifier flags and turns each accepted
// byte into a lookup request for the back end.
// ----------------------------------------------------------------------------
module sc1_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sc1_in_if.sink        req_i,
  input  logic          push_ready_i,
  output logic          push_o,
  output sc1_pkg::req_t push_data_o
);
  import sc1_pkg::*;

  logic             prefix_q, prefix_d;
  mods_t            mods_q, mods_d;
  logic [ByteW-1:0] b;
  logic [CharW-1:0] lo;
  logic             ext;
  kind_e            kind;

  assign req_i.ready = push_ready_i;
  assign push_o      = req_i.valid & push_ready_i;
  assign b           = req_i.scan_byte;
  assign lo          = b[CharW-1:0];
  assign ext         = prefix_q;

  always_comb begin
    prefix_d = prefix_q;
    mods_d   = mods_q;
    kind     = KIND_SILENT;
    if (b == PREFIX_BYTE) begin
      prefix_d = 1'b1;
    end else begin
      prefix_d = 1'b0;
      if (b[ByteW-1]) begin
        if (lo == MK_CTRL) begin
          mods_d.ctrl = 1'b0;
        end else if (lo == MK_ALT) begin
          mods_d.alt = 1'b0;
        end else if (!ext && (lo == MK_LSHIFT || lo == MK_RSHIFT)) begin
          mods_d.shift = 1'b0;
        end
      end else begin
        priority if (!ext && (lo == MK_LSHIFT || lo == MK_RSHIFT)) begin
          mods_d.shift = 1'b1;
        end else if (lo == MK_CTRL) begin
          mods_d.ctrl = 1'b1;
        end else if (lo == MK_ALT) begin
          mods_d.alt = 1'b1;
        end else if (!ext && lo == MK_CAPS) begin
          mods_d.caps = ~mods_q.caps;
        end else if (ext || b > MAX_CODE) begin
          kind = KIND_RANGE;
        end else begin
          kind = KIND_LOOKUP;
        end
      end
    end
  end

  always_comb begin
    push_data_o.kind  = kind;
    push_data_o.key   = b[KeyW-1:0];
    push_data_o.upper = mods_d.shift | mods_d.caps;
    push_data_o.mods  = mods_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 1'b0;
      mods_q   <= '0;
    end else if (push_o) begin
      prefix_q <= prefix_d;
      mods_q   <= mods_d;
    end
  end

  a_prefix_arm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && b == PREFIX_BYTE) |=> prefix_q)
    else $error("prefix byte did not arm the extended flag");

  a_caps_toggle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !prefix_q && b == {1'b0, MK_CAPS}) |=> (mods_q.caps != $past(mods_q.caps)))
    else $error("caps lock make did not toggle");

endmodule

### sv/sc1_queue.sv
// ----------------------------------------------------------------------------
// sc1_queue: request queue between classifier and lookup stage
// Small circular buffer, lets the front and back stall independently.
// ----------------------------------------------------------------------------
module sc1_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sc1_pkg::req_t push_data_i,
  output logic          push_ready_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output sc1_pkg::req_t head_o
);
  import sc1_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue occupancy exceeds depth");

  a_ptr_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CntW'(Depth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with occupancy");

endmodule

### sv/sc1_back.sv
// ----------------------------------------------------------------------------
// sc1_back: keymap lookup and result register
// Reads the keymap column for a request, derives the action and holds the
// result until the sink takes it.
// ----------------------------------------------------------------------------
module sc1_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  sc1_pkg::req_t head_i,
  output logic          pop_o,
  sc1_out_if.source     rsp_o
);
  import sc1_pkg::*;

  logic             out_valid_q;
  action_e          action_q, action_d;
  logic [CharW-1:0] char_q, char_d;
  mods_t            mods_q;
  logic [CharW-1:0] ch;

  assign pop_o = head_valid_i & (~out_valid_q | rsp_o.ready);
  assign ch    = head_i.upper ? SHIFT_COL[head_i.key] : PLAIN_COL[head_i.key];

  always_comb begin
    action_d = ACT_NONE;
    char_d   = CHAR_NUL;
    unique case (head_i.kind)
      KIND_RANGE:  action_d = ACT_UNKNOWN_KEY;
      KIND_LOOKUP: begin
        priority if (ch == CHAR_NUL) begin
          action_d = ACT_UNKNOWN_CHAR;
        end else if (ch == KEY_TAB) begin
          action_d = ACT_PRINT;
          char_d   = CHAR_SPC;
        end else if (ch == KEY_ESC || ch == KEY_ENT) begin
          action_d = ACT_NONE;
        end else if (ch == KEY_BS) begin
          action_d = ACT_BACKSPACE;
        end else begin
          action_d = ACT_PRINT;
          char_d   = ch;
        end
      end
      default:     action_d = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | rsp_o.ready) begin
      out_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      action_q <= action_d;
      char_q   <= char_d;
      mods_q   <= head_i.mods;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.action     = action_q;
  assign rsp_o.char_code  = char_q;
  assign rsp_o.shift_held = mods_q.shift;
  assign rsp_o.ctrl_held  = mods_q.ctrl;
  assign rsp_o.alt_held   = mods_q.alt;
  assign rsp_o.caps_on    = mods_q.caps;

  a_char_only_print : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && action_q != ACT_PRINT) |-> (char_q == CHAR_NUL))
    else $error("character code set on a non-print result");

  a_print_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && action_q == ACT_PRINT) |-> (char_q != CHAR_NUL))
    else $error("print result carries a null character");

endmodule
